// ===== rtl/core/apci_pkg.sv =====
package apci_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] START_BYTE = 8'h68;
    localparam logic [7:0] MIN_LENGTH = 8'd4;
    localparam logic [7:0] TYPE_LENGTH = 8'd5;
    localparam logic [7:0] FULL_LENGTH = 8'd10;
    localparam logic [7:0] CAUSE_MASK = 8'h3f;

    localparam logic [7:0] CTRL_STARTDT_ACT = 8'h07;
    localparam logic [7:0] CTRL_STARTDT_CON = 8'h0b;
    localparam logic [7:0] CTRL_STOPDT_ACT = 8'h13;
    localparam logic [7:0] CTRL_STOPDT_CON = 8'h23;
    localparam logic [7:0] CTRL_TESTFR_ACT = 8'h43;
    localparam logic [7:0] CTRL_TESTFR_CON = 8'h83;

    localparam logic [2:0] ERR_OK = 3'd0;
    localparam logic [2:0] ERR_NO_START = 3'd1;
    localparam logic [2:0] ERR_TRUNCATED = 3'd2;
    localparam logic [2:0] ERR_BAD_LENGTH = 3'd3;
    localparam logic [2:0] ERR_CUT_OFF = 3'd4;

    localparam logic [1:0] KIND_I = 2'd0;
    localparam logic [1:0] KIND_S = 2'd1;
    localparam logic [1:0] KIND_U = 2'd2;

    localparam logic [1:0] ASDU_NONE = 2'd0;
    localparam logic [1:0] ASDU_TYPE = 2'd1;
    localparam logic [1:0] ASDU_FULL = 2'd2;

    localparam logic [2:0] UFN_NONE = 3'd0;
    localparam logic [2:0] UFN_STARTDT_ACT = 3'd1;
    localparam logic [2:0] UFN_STARTDT_CON = 3'd2;
    localparam logic [2:0] UFN_STOPDT_ACT = 3'd3;
    localparam logic [2:0] UFN_STOPDT_CON = 3'd4;
    localparam logic [2:0] UFN_TESTFR_ACT = 3'd5;
    localparam logic [2:0] UFN_TESTFR_CON = 3'd6;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_JUNK,
        PH_LEN,
        PH_BODY,
        PH_SKIP
    } phase_t;

    typedef struct packed {
        logic [2:0]  error_code;
        logic [1:0]  kind;
        logic [14:0] send_seq;
        logic [14:0] recv_seq;
        logic [7:0]  type_id;
        logic [1:0]  asdu_fields;
        logic [5:0]  cause;
        logic [15:0] common_address;
        logic [2:0]  u_function;
        logic [15:0] byte_count;
        logic [15:0] start_offset;
        logic        run_end;
    } result_t;

    function automatic logic [2:0] u_code(input logic [7:0] c0);
        logic [2:0] code;
        case (c0)
            CTRL_STARTDT_ACT: code = UFN_STARTDT_ACT;
            CTRL_STARTDT_CON: code = UFN_STARTDT_CON;
            CTRL_STOPDT_ACT:  code = UFN_STOPDT_ACT;
            CTRL_STOPDT_CON:  code = UFN_STOPDT_CON;
            CTRL_TESTFR_ACT:  code = UFN_TESTFR_ACT;
            CTRL_TESTFR_CON:  code = UFN_TESTFR_CON;
            default:          code = UFN_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [15:0] to_start(input logic [OFFSET_BITS-1:0] off);
        logic [31:0] wide;
        wide = 32'(off);
        return wide[15:0];
    endfunction

    function automatic result_t make_result(
        input logic [2:0]             code,
        input logic [15:0]            count,
        input logic [OFFSET_BITS-1:0] start
    );
        result_t r;
        r = '0;
        r.error_code = code;
        r.byte_count = count;
        r.start_offset = to_start(start);
        return r;
    endfunction

endpackage

// ===== rtl/core/apci_byte_if.sv =====
interface apci_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       payload_end;

    modport source (output valid, output data_byte, output payload_end, input ready);
    modport sink (input valid, input data_byte, input payload_end, output ready);
endinterface

// ===== rtl/core/apci_result_if.sv =====
interface apci_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  error_code;
    logic [1:0]  kind;
    logic [14:0] send_seq;
    logic [14:0] recv_seq;
    logic [7:0]  type_id;
    logic [1:0]  asdu_fields;
    logic [5:0]  cause;
    logic [15:0] common_address;
    logic [2:0]  u_function;
    logic [15:0] byte_count;
    logic [15:0] start_offset;
    logic        run_end;

    modport source (
        output valid, output error_code, output kind, output send_seq, output recv_seq,
        output type_id, output asdu_fields, output cause, output common_address,
        output u_function, output byte_count, output start_offset, output run_end,
        input ready
    );
    modport sink (
        input valid, input error_code, input kind, input send_seq, input recv_seq,
        input type_id, input asdu_fields, input cause, input common_address,
        input u_function, input byte_count, input start_offset, input run_end,
        output ready
    );
endinterface

// ===== rtl/core/iec104_apci_frame_parser_core.sv =====
// Splits a byte stream into IEC 104 APCI frames, one byte per clock cycle. Each byte
// transfer updates the parser state in the same cycle and produces zero, one or two
// results (a junk run followed by a start byte at the payload end gives two). Results
// are written into a four-entry result queue and leave it one per cycle, the cycle
// after the byte that caused them at the earliest. The byte input accepts a transfer
// whenever the queue has at least two free entries, so with the result side always
// ready the block sustains one byte per cycle; only a stalled result side holds it.
module iec104_apci_frame_parser_core
    import apci_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    apci_byte_if.sink     stream,
    apci_result_if.source results
);

    phase_t                   phase_reg, phase_next;
    logic [OFFSET_BITS-1:0]   offset_reg, offset_next;
    logic [OFFSET_BITS-1:0]   run_start_reg, run_start_next;
    logic [15:0]              run_count_reg, run_count_next;
    logic [7:0]               decl_len_reg, decl_len_next;
    logic [7:0]               frame_index_reg, frame_index_next;
    logic [31:0]              control_reg, control_next;
    logic [7:0]               held_type_reg, held_type_next;
    logic [5:0]               held_cause_reg, held_cause_next;
    logic [15:0]              held_addr_reg, held_addr_next;

    result_t                  queue_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]  count_reg;

    logic                     take;
    logic                     pop;
    logic                     is_start;
    logic                     last;
    logic [7:0]               b;
    logic [8:0]               index_plus_one;
    logic [7:0]               skip_index;
    logic [1:0]               push_n;
    result_t                  res0, res1, frame_res;

    assign b = stream.data_byte;
    assign last = stream.payload_end;
    assign is_start = (b == START_BYTE);
    assign stream.ready = (count_reg <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 2));
    assign take = stream.valid && stream.ready;
    assign pop = results.valid && results.ready;
    assign index_plus_one = {1'b0, frame_index_reg} + 9'd1;
    assign skip_index = frame_index_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_JUNK:
            begin
                if (is_start)
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (b < MIN_LENGTH)
                begin
                    phase_next = (b == 8'd0 || last) ? PH_IDLE : PH_SKIP;
                end
                else
                begin
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (index_plus_one == {1'b0, decl_len_reg})
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_SKIP:
            begin
                if (skip_index >= decl_len_reg)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = is_start ? PH_LEN : PH_JUNK;
            end
        endcase
        if (last)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_comb
    begin
        frame_res = '0;
        frame_res.byte_count = 16'({1'b0, decl_len_reg} + 9'd2);
        frame_res.start_offset = to_start(run_start_reg);
        if (!control_next[0])
        begin
            frame_res.kind = KIND_I;
            frame_res.send_seq = control_next[15:1];
            frame_res.recv_seq = control_next[31:17];
            if (decl_len_reg >= TYPE_LENGTH)
            begin
                frame_res.type_id = held_type_next;
                frame_res.asdu_fields = ASDU_TYPE;
            end
            if (decl_len_reg >= FULL_LENGTH)
            begin
                frame_res.asdu_fields = ASDU_FULL;
                frame_res.cause = held_cause_next;
                frame_res.common_address = held_addr_next;
            end
        end
        else if (!control_next[1])
        begin
            frame_res.kind = KIND_S;
            frame_res.recv_seq = control_next[31:17];
        end
        else
        begin
            frame_res.kind = KIND_U;
            frame_res.u_function = u_code(control_next[7:0]);
        end
    end

    always_comb
    begin
        offset_next = last ? '0 : offset_reg + OFFSET_BITS'(1);
        run_start_next = run_start_reg;
        run_count_next = run_count_reg;
        decl_len_next = decl_len_reg;
        frame_index_next = frame_index_reg;
        control_next = control_reg;
        held_type_next = held_type_reg;
        held_cause_next = held_cause_reg;
        held_addr_next = held_addr_reg;
        res0 = '0;
        res1 = '0;
        push_n = 2'd0;
        case (phase_reg)
            PH_JUNK:
            begin
                if (is_start)
                begin
                    res0 = make_result(ERR_NO_START, run_count_reg, run_start_reg);
                    push_n = 2'd1;
                    run_start_next = offset_reg;
                    if (last)
                    begin
                        res1 = make_result(ERR_TRUNCATED, 16'd1, offset_reg);
                        push_n = 2'd2;
                    end
                end
                else
                begin
                    if (run_count_reg != 16'hffff)
                    begin
                        run_count_next = run_count_reg + 16'd1;
                    end
                    if (last)
                    begin
                        res0 = make_result(ERR_NO_START, run_count_next, run_start_reg);
                        push_n = 2'd1;
                    end
                end
            end
            PH_LEN:
            begin
                decl_len_next = b;
                frame_index_next = '0;
                control_next = '0;
                held_type_next = '0;
                held_cause_next = '0;
                held_addr_next = '0;
                if (b < MIN_LENGTH)
                begin
                    if (b == 8'd0 || last)
                    begin
                        res0 = make_result(ERR_BAD_LENGTH, 16'd2, run_start_reg);
                        push_n = 2'd1;
                    end
                end
                else if (last)
                begin
                    res0 = make_result(ERR_CUT_OFF, 16'd2, run_start_reg);
                    push_n = 2'd1;
                end
            end
            PH_BODY:
            begin
                if (frame_index_reg < 8'd4)
                begin
                    control_next[{frame_index_reg[1:0], 3'b000} +: 8] = b;
                end
                else if (frame_index_reg == 8'd4)
                begin
                    held_type_next = b;
                end
                else if (frame_index_reg == 8'd6)
                begin
                    held_cause_next = 6'(b & CAUSE_MASK);
                end
                else if (frame_index_reg == 8'd8)
                begin
                    held_addr_next[7:0] = b;
                end
                else if (frame_index_reg == 8'd9)
                begin
                    held_addr_next[15:8] = b;
                end
                if (index_plus_one == {1'b0, decl_len_reg})
                begin
                    res0 = frame_res;
                    push_n = 2'd1;
                end
                else if (last)
                begin
                    res0 = make_result(ERR_CUT_OFF, 16'({1'b0, frame_index_reg} + 9'd3),
                                       run_start_reg);
                    push_n = 2'd1;
                end
                else
                begin
                    frame_index_next = index_plus_one[7:0];
                end
            end
            PH_SKIP:
            begin
                frame_index_next = skip_index;
                if (skip_index >= decl_len_reg || last)
                begin
                    res0 = make_result(ERR_BAD_LENGTH, 16'({1'b0, skip_index} + 9'd2),
                                       run_start_reg);
                    push_n = 2'd1;
                end
            end
            default:
            begin
                run_start_next = offset_reg;
                if (is_start)
                begin
                    if (last)
                    begin
                        res0 = make_result(ERR_TRUNCATED, 16'd1, offset_reg);
                        push_n = 2'd1;
                    end
                end
                else
                begin
                    run_count_next = 16'd1;
                    if (last)
                    begin
                        res0 = make_result(ERR_NO_START, 16'd1, offset_reg);
                        push_n = 2'd1;
                    end
                end
            end
        endcase
        if (push_n == 2'd1)
        begin
            res0.run_end = 1'b1;
        end
        if (push_n == 2'd2)
        begin
            res1.run_end = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            offset_reg <= '0;
            run_start_reg <= '0;
            run_count_reg <= '0;
            decl_len_reg <= '0;
            frame_index_reg <= '0;
            control_reg <= '0;
            held_type_reg <= '0;
            held_cause_reg <= '0;
            held_addr_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            offset_reg <= offset_next;
            run_start_reg <= run_start_next;
            run_count_reg <= run_count_next;
            decl_len_reg <= decl_len_next;
            frame_index_reg <= frame_index_next;
            control_reg <= control_next;
            held_type_reg <= held_type_next;
            held_cause_reg <= held_cause_next;
            held_addr_reg <= held_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && push_n != 2'd0)
        begin
            queue_mem[wr_ptr_reg] <= res0;
        end
        if (take && push_n == 2'd2)
        begin
            queue_mem[wr_ptr_reg + QUEUE_PTR_BITS'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_BITS'(push_n);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            count_reg <= count_reg + (take ? (QUEUE_PTR_BITS+1)'(push_n) : '0)
                         - (QUEUE_PTR_BITS+1)'(pop);
        end
    end

    assign results.valid = (count_reg != '0);
    assign results.error_code = queue_mem[rd_ptr_reg].error_code;
    assign results.kind = queue_mem[rd_ptr_reg].kind;
    assign results.send_seq = queue_mem[rd_ptr_reg].send_seq;
    assign results.recv_seq = queue_mem[rd_ptr_reg].recv_seq;
    assign results.type_id = queue_mem[rd_ptr_reg].type_id;
    assign results.asdu_fields = queue_mem[rd_ptr_reg].asdu_fields;
    assign results.cause = queue_mem[rd_ptr_reg].cause;
    assign results.common_address = queue_mem[rd_ptr_reg].common_address;
    assign results.u_function = queue_mem[rd_ptr_reg].u_function;
    assign results.byte_count = queue_mem[rd_ptr_reg].byte_count;
    assign results.start_offset = queue_mem[rd_ptr_reg].start_offset;
    assign results.run_end = queue_mem[rd_ptr_reg].run_end;

    // The queue never holds more entries than it has.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // The last byte of a payload always closes whatever run or frame is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        take && stream.payload_end |-> push_n != 2'd0)
        else $error("payload end produced no result");

    // After the last byte of a payload the parser starts over at offset zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        take && stream.payload_end |=> offset_reg == '0 && phase_reg == PH_IDLE)
        else $error("parser not restarted after payload end");

    // Two results from one byte only come from a start byte at the payload end.
    assert property (@(posedge clk) disable iff (!rst_n)
        take && push_n == 2'd2 |-> stream.payload_end && is_start)
        else $error("unexpected double result");

endmodule

// ===== tb/sv/apci_frame_checker.sv =====
`timescale 1ns / 1ps

module apci_frame_checker
    import apci_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    apci_byte_if   stream,
    apci_result_if results,
    output int     mismatches,
    output int     waiting
);

    phase_t                 parse_phase;
    logic [OFFSET_BITS-1:0] byte_pos;
    logic [OFFSET_BITS-1:0] run_start;
    logic [15:0]            junk_count;
    logic [7:0]             frame_len;
    logic [7:0]             body_index;
    logic [31:0]            ctrl_word;
    logic [7:0]             held_type;
    logic [5:0]             held_cause;
    logic [15:0]            held_addr;

    result_t frames_due[$];
    result_t want;

    function automatic result_t error_result(
        input logic [2:0]             code,
        input int                     count,
        input logic [OFFSET_BITS-1:0] start
    );
        result_t r;
        r = '0;
        r.error_code = code;
        r.byte_count = 16'(count);
        r.start_offset = 16'(start);
        return r;
    endfunction

    function automatic logic [2:0] u_function_of(input logic [7:0] c0);
        logic [2:0] f;
        case (c0)
            CTRL_STARTDT_ACT: f = UFN_STARTDT_ACT;
            CTRL_STARTDT_CON: f = UFN_STARTDT_CON;
            CTRL_STOPDT_ACT:  f = UFN_STOPDT_ACT;
            CTRL_STOPDT_CON:  f = UFN_STOPDT_CON;
            CTRL_TESTFR_ACT:  f = UFN_TESTFR_ACT;
            CTRL_TESTFR_CON:  f = UFN_TESTFR_CON;
            default:          f = UFN_NONE;
        endcase
        return f;
    endfunction

    function automatic result_t frame_result();
        result_t    r;
        logic [7:0] c0;
        c0 = ctrl_word[7:0];
        r = error_result(ERR_OK, int'(frame_len) + 2, run_start);
        if (!c0[0])
        begin
            r.kind = KIND_I;
            r.send_seq = ctrl_word[15:1];
            r.recv_seq = ctrl_word[31:17];
            if (frame_len >= TYPE_LENGTH)
            begin
                r.type_id = held_type;
                r.asdu_fields = ASDU_TYPE;
            end
            if (frame_len >= FULL_LENGTH)
            begin
                r.asdu_fields = ASDU_FULL;
                r.cause = held_cause;
                r.common_address = held_addr;
            end
        end
        else if (c0[1:0] == 2'b01)
        begin
            r.kind = KIND_S;
            r.recv_seq = ctrl_word[31:17];
        end
        else
        begin
            r.kind = KIND_U;
            r.u_function = u_function_of(c0);
        end
        return r;
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic last);
        result_t                made [2];
        int                     n;
        int                     p;
        logic [OFFSET_BITS-1:0] here;
        n = 0;
        here = byte_pos;
        case (parse_phase)
            PH_JUNK:
            begin
                if (b == START_BYTE)
                begin
                    made[n] = error_result(ERR_NO_START, int'(junk_count), run_start);
                    n++;
                    run_start = here;
                    parse_phase = PH_LEN;
                    if (last)
                    begin
                        made[n] = error_result(ERR_TRUNCATED, 1, here);
                        n++;
                    end
                end
                else
                begin
                    if (junk_count != 16'hffff)
                        junk_count = junk_count + 16'd1;
                    if (last)
                    begin
                        made[n] = error_result(ERR_NO_START, int'(junk_count), run_start);
                        n++;
                    end
                end
            end
            PH_LEN:
            begin
                frame_len = b;
                body_index = '0;
                ctrl_word = '0;
                held_type = '0;
                held_cause = '0;
                held_addr = '0;
                if (b < MIN_LENGTH)
                begin
                    if (b == 8'd0 || last)
                    begin
                        made[n] = error_result(ERR_BAD_LENGTH, 2, run_start);
                        n++;
                        parse_phase = PH_IDLE;
                    end
                    else
                        parse_phase = PH_SKIP;
                end
                else
                begin
                    parse_phase = PH_BODY;
                    if (last)
                    begin
                        made[n] = error_result(ERR_CUT_OFF, 2, run_start);
                        n++;
                    end
                end
            end
            PH_BODY:
            begin
                p = int'(body_index);
                if (p < 4)
                    ctrl_word[8*p +: 8] = b;
                else if (p == 4)
                    held_type = b;
                else if (p == 6)
                    held_cause = b[5:0];
                else if (p == 8)
                    held_addr[7:0] = b;
                else if (p == 9)
                    held_addr[15:8] = b;
                if (p + 1 == int'(frame_len))
                begin
                    made[n] = frame_result();
                    n++;
                    parse_phase = PH_IDLE;
                end
                else if (last)
                begin
                    made[n] = error_result(ERR_CUT_OFF, p + 3, run_start);
                    n++;
                end
                else
                    body_index = 8'(p + 1);
            end
            PH_SKIP:
            begin
                body_index = body_index + 8'd1;
                if (body_index >= frame_len || last)
                begin
                    made[n] = error_result(ERR_BAD_LENGTH, int'(body_index) + 2, run_start);
                    n++;
                    parse_phase = PH_IDLE;
                end
            end
            default:
            begin
                run_start = here;
                if (b == START_BYTE)
                begin
                    parse_phase = PH_LEN;
                    if (last)
                    begin
                        made[n] = error_result(ERR_TRUNCATED, 1, here);
                        n++;
                    end
                end
                else
                begin
                    parse_phase = PH_JUNK;
                    junk_count = 16'd1;
                    if (last)
                    begin
                        made[n] = error_result(ERR_NO_START, 1, here);
                        n++;
                    end
                end
            end
        endcase
        if (n > 0)
            made[n-1].run_end = 1'b1;
        for (int i = 0; i < n; i++)
            frames_due.push_back(made[i]);
        if (last)
        begin
            parse_phase = PH_IDLE;
            byte_pos = '0;
        end
        else
            byte_pos = here + OFFSET_BITS'(1);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase = PH_IDLE;
            byte_pos = '0;
            run_start = '0;
            junk_count = '0;
            frame_len = '0;
            body_index = '0;
            ctrl_word = '0;
            held_type = '0;
            held_cause = '0;
            held_addr = '0;
            frames_due.delete();
            mismatches = 0;
            waiting = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("result transfer with no result expected");
                    mismatches++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    check_field("error_code", 32'(want.error_code),
                                32'(results.error_code));
                    check_field("kind", 32'(want.kind), 32'(results.kind));
                    check_field("send_seq", 32'(want.send_seq), 32'(results.send_seq));
                    check_field("recv_seq", 32'(want.recv_seq), 32'(results.recv_seq));
                    check_field("type_id", 32'(want.type_id), 32'(results.type_id));
                    check_field("asdu_fields", 32'(want.asdu_fields),
                                32'(results.asdu_fields));
                    check_field("cause", 32'(want.cause), 32'(results.cause));
                    check_field("common_address", 32'(want.common_address),
                                32'(results.common_address));
                    check_field("u_function", 32'(want.u_function),
                                32'(results.u_function));
                    check_field("byte_count", 32'(want.byte_count),
                                32'(results.byte_count));
                    check_field("start_offset", 32'(want.start_offset),
                                32'(results.start_offset));
                    check_field("run_end", 32'(want.run_end), 32'(results.run_end));
                end
            end
            if (stream.valid && stream.ready)
                take_byte(stream.data_byte, stream.payload_end);
            waiting = frames_due.size();
        end
    end

endmodule

// ===== tb/sv/iec104_apci_frame_parser_core_test.sv =====
`timescale 1ns / 1ps

module iec104_apci_frame_parser_core_test;
    import apci_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_BYTES = 800;
    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   waiting;
    int   cycles = 0;
    int   bytes_sent = 0;
    int   burst_left = 0;
    logic pace_gaps = 1'b0;
    logic hold_req = 1'b0;

    logic [7:0] payload_q[$];

    apci_byte_if   byte_ch ();
    apci_result_if res_ch ();

    iec104_apci_frame_parser_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (byte_ch),
        .results (res_ch)
    );

    apci_frame_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (byte_ch),
        .results    (res_ch),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        byte_ch.valid = 1'b1;
        byte_ch.data_byte = b;
        byte_ch.payload_end = last;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        bytes_sent++;
        if (pace_gaps)
        begin
            if (burst_left == 0)
            begin
                @(negedge clk);
                byte_ch.valid = 1'b0;
                byte_ch.data_byte = 8'($urandom);
                byte_ch.payload_end = 1'($urandom);
                repeat ($urandom_range(0, 6)) @(negedge clk);
                burst_left = $urandom_range(1, 40);
            end
            else
                burst_left--;
        end
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        byte_ch.valid = 1'b0;
        while (waiting != 0)
            @(negedge clk);
    endtask

    task automatic flush_payload();
        int i;
        for (i = 0; i < payload_q.size(); i++)
            push_byte(payload_q[i], i == payload_q.size() - 1);
        payload_q.delete();
    endtask

    function automatic void put_frame(input logic [7:0] len, input logic [7:0] c0,
                                      input logic random_body, input logic [7:0] fill);
        int i;
        payload_q.push_back(START_BYTE);
        payload_q.push_back(len);
        if (len != 8'd0)
            payload_q.push_back(c0);
        for (i = 1; i < int'(len); i++)
            payload_q.push_back(random_body ? 8'($urandom) : fill);
    endfunction

    function automatic void put_junk(input int count);
        logic [7:0] b;
        for (int i = 0; i < count; i++)
        begin
            do
                b = 8'($urandom);
            while (b == START_BYTE);
            payload_q.push_back(b);
        end
    endfunction

    function automatic logic [7:0] u_ctrl();
        logic [7:0] c;
        case ($urandom_range(0, 6))
            0: c = CTRL_STARTDT_ACT;
            1: c = CTRL_STARTDT_CON;
            2: c = CTRL_STOPDT_ACT;
            3: c = CTRL_STOPDT_CON;
            4: c = CTRL_TESTFR_ACT;
            5: c = CTRL_TESTFR_CON;
            default: c = {6'($urandom), 2'b11};
        endcase
        return c;
    endfunction

    function automatic logic [7:0] i_length();
        if ($urandom_range(0, 49) == 0)
            return 8'($urandom_range(100, 255));
        return 8'($urandom_range(4, 16));
    endfunction

    function automatic void put_random_payload();
        int parts;
        parts = $urandom_range(1, 4);
        repeat (parts)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: put_frame(i_length(), {7'($urandom), 1'b0}, 1'b1, 8'h00);
                3: put_frame(8'($urandom_range(4, 6)), {6'($urandom), 2'b01}, 1'b1, 8'h00);
                4: put_frame(8'($urandom_range(4, 6)), u_ctrl(), 1'b1, 8'h00);
                5: put_frame(8'($urandom_range(10, 24)), {7'($urandom), 1'b0}, 1'b1, 8'h00);
                6: put_junk($urandom_range(1, 6));
                7: put_frame(8'($urandom_range(0, 3)), 8'($urandom), 1'b1, 8'h00);
                default:
                    repeat ($urandom_range(1, 6))
                        payload_q.push_back($urandom_range(0, 3) == 0 ? START_BYTE
                                                                       : 8'($urandom));
            endcase
        end
        if ($urandom_range(0, 99) < 15 && payload_q.size() > 1)
            repeat ($urandom_range(1, payload_q.size() - 1))
                payload_q.delete(payload_q.size() - 1);
    endfunction

    initial
    begin
        int mode;
        int span;
        int tick;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        tick = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 120);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                if (hold_req)
                begin
                    res_ch.ready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0: res_ch.ready = 1'b1;
                    1: res_ch.ready = 1'($urandom);
                    2: res_ch.ready = ($urandom_range(0, 3) == 0);
                    default: res_ch.ready = (tick % 3 != 0);
                endcase
            end
        end
    end

    initial
    begin
        int payloads;
        int random_base;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.payload_end = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        payload_q.push_back(START_BYTE);
        flush_payload();
        payload_q = '{8'h00, 8'hff, START_BYTE};
        flush_payload();
        payload_q.push_back(8'h12);
        flush_payload();
        payload_q = '{START_BYTE, 8'h00, START_BYTE, 8'h02, 8'haa, 8'h55,
                      START_BYTE, 8'h03, 8'h01};
        flush_payload();
        payload_q = '{START_BYTE, 8'h01};
        flush_payload();
        payload_q = '{START_BYTE, 8'h04};
        flush_payload();
        put_frame(8'd4, CTRL_STARTDT_ACT, 1'b0, 8'h00);
        put_frame(8'd4, CTRL_STARTDT_CON, 1'b0, 8'h00);
        put_frame(8'd4, CTRL_STOPDT_ACT, 1'b0, 8'h00);
        put_frame(8'd4, CTRL_STOPDT_CON, 1'b0, 8'h00);
        put_frame(8'd4, CTRL_TESTFR_ACT, 1'b0, 8'h00);
        put_frame(8'd4, CTRL_TESTFR_CON, 1'b0, 8'h00);
        put_frame(8'd4, 8'hff, 1'b0, 8'hff);
        flush_payload();
        put_frame(8'd4, 8'h01, 1'b0, 8'hff);
        put_frame(8'd4, 8'hfd, 1'b0, 8'h00);
        put_frame(8'd4, 8'hfe, 1'b0, 8'hff);
        put_frame(8'd5, 8'h00, 1'b0, 8'h00);
        put_frame(8'd9, 8'hfe, 1'b0, 8'hff);
        put_frame(8'd10, 8'hfe, 1'b0, 8'hff);
        put_frame(8'd14, 8'h00, 1'b1, 8'h00);
        flush_payload();
        put_frame(8'd10, 8'h02, 1'b1, 8'h00);
        repeat (4) payload_q.delete(payload_q.size() - 1);
        flush_payload();
        put_frame(8'd255, 8'h00, 1'b1, 8'h00);
        flush_payload();
        wait_results_done();

        payloads = 0;
        random_base = bytes_sent;
        while (bytes_sent - random_base < RANDOM_BYTES)
        begin
            pace_gaps = ($urandom_range(0, 3) != 0);
            if (payloads == 20)
            begin
                pace_gaps = 1'b0;
                hold_req = 1'b1;
            end
            if (payloads % 60 == 59)
                wait_results_done();
            put_random_payload();
            flush_payload();
            payloads++;
        end
        wait_results_done();

        repeat (50) @(posedge clk);
        if (mismatches == 0 && waiting == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/apci_pkg.sv
rtl/core/apci_byte_if.sv
rtl/core/apci_result_if.sv
rtl/core/iec104_apci_frame_parser_core.sv
tb/sv/apci_frame_checker.sv
tb/sv/iec104_apci_frame_parser_core_test.sv
